// ===== rtl/brl_pkg.sv =====
// ============================================================================
// Burst record loader package
// Shared types and constants for the burst record register loader.
// ============================================================================
package brl_pkg;

    // Parse phases
    localparam logic [2:0] PH_LEN    = 3'd0;
    localparam logic [2:0] PH_ADDR_L = 3'd1;
    localparam logic [2:0] PH_ADDR_H = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    // Input operations
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_REG_BASE      = 2'd0;
    localparam logic [1:0] CFG_REGION_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MAC_ADDRESS   = 2'd2;

    // Parsing constants
    localparam logic [7:0]  ADDR_LOW_MASK  = 8'hFE;
    localparam logic [16:0] TABLE_SKIP     = 17'd10;   // 7 bytes plus 3 for rounding up
    localparam logic [16:0] ALIGN_MASK     = 17'h1FFFC; // round down to 4 bytes
    localparam logic [16:0] WORD_TAIL      = 17'd3;
    localparam logic [31:0] WORD_STEP      = 32'd4;
    localparam logic [15:0] REGION_RESET   = 16'd1024;

    // Image offsets patched with station address bytes
    localparam logic [15:0] MAC_OFS_0 = 16'd3;
    localparam logic [15:0] MAC_OFS_1 = 16'd4;
    localparam logic [15:0] MAC_OFS_2 = 16'd5;
    localparam logic [15:0] MAC_OFS_3 = 16'd6;
    localparam logic [15:0] MAC_OFS_4 = 16'd10;
    localparam logic [15:0] MAC_OFS_5 = 16'd11;

    typedef struct packed {
        logic       op;
        logic [7:0] image_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] table_length;
        logic [15:0] table_offset;
        logic [31:0] write_data;
        logic [31:0] write_address;
        logic [1:0]  kind;
    } t_result;

    typedef struct packed {
        logic [31:0] reg_base;
        logic [15:0] region_length;
        logic [47:0] mac_address;
    } t_cfg;

endpackage

// ===== rtl/brl_in_stage.sv =====
// ============================================================================
// Input register stage
// Captures one input transaction and holds it until the parser takes it.
// ============================================================================
module brl_in_stage
    import brl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Ready whenever the register is empty or drains this cycle
    assign o_ready = !r_valid || i_take;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/brl_parser.sv =====
// ============================================================================
// Burst record parser
// Holds the parse state; unless output stalls, turns one image byte per cycle
// into at most one result: a register write, a finished or a malformed report.
// ============================================================================
module brl_parser
    import brl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_item_valid,
    input  t_in_item i_item,
    input  logic     i_go,
    output logic     o_res_valid,
    output t_result  o_res
);

    logic [15:0] r_byte_position, n_byte_position;
    logic [2:0]  r_phase,         n_phase;
    logic [7:0]  r_words_left,    n_words_left;
    logic [31:0] r_burst_address, n_burst_address;
    logic [23:0] r_word_acc,      n_word_acc;
    logic [1:0]  r_byte_in_word,  n_byte_in_word;

    logic [7:0]  byte_val;
    logic        pos_out;
    logic [16:0] table_off;
    logic        table_out;
    logic        word_out;

    // Station address patch of the current byte
    always_comb begin
        case (r_byte_position)
            MAC_OFS_0: byte_val = i_cfg.mac_address[7:0];
            MAC_OFS_1: byte_val = i_cfg.mac_address[15:8];
            MAC_OFS_2: byte_val = i_cfg.mac_address[23:16];
            MAC_OFS_3: byte_val = i_cfg.mac_address[31:24];
            MAC_OFS_4: byte_val = i_cfg.mac_address[39:32];
            MAC_OFS_5: byte_val = i_cfg.mac_address[47:40];
            default:   byte_val = i_item.image_byte;
        endcase
    end

    // Bounds checks against the region length
    assign pos_out   = r_byte_position >= i_cfg.region_length;
    assign table_off = ({1'b0, r_byte_position} + TABLE_SKIP) & ALIGN_MASK;
    assign table_out = table_off >= {1'b0, i_cfg.region_length};
    assign word_out  = ({1'b0, r_byte_position} + WORD_TAIL) >= {1'b0, i_cfg.region_length};

    // Next state and result
    always_comb begin
        n_byte_position = r_byte_position;
        n_phase         = r_phase;
        n_words_left    = r_words_left;
        n_burst_address = r_burst_address;
        n_word_acc      = r_word_acc;
        n_byte_in_word  = r_byte_in_word;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_item.op == OP_RESTART) begin
            n_byte_position = '0;
            n_phase         = PH_LEN;
            n_words_left    = '0;
            n_burst_address = '0;
            n_word_acc      = '0;
            n_byte_in_word  = '0;
        end else if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
            n_byte_position = r_byte_position + 16'd1;
            case (r_phase)
                PH_LEN: begin
                    if (pos_out) begin
                        n_phase     = PH_ERROR;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BAD;
                    end else if (byte_val == 8'd0) begin
                        o_res_valid = 1'b1;
                        if (table_out) begin
                            n_phase    = PH_ERROR;
                            o_res.kind = KIND_BAD;
                        end else begin
                            n_phase            = PH_DONE;
                            o_res.kind         = KIND_DONE;
                            o_res.table_offset = table_off[15:0];
                            o_res.table_length = i_cfg.region_length - table_off[15:0];
                        end
                    end else begin
                        n_words_left = byte_val;
                        n_phase      = PH_ADDR_L;
                    end
                end
                PH_ADDR_L: begin
                    if (pos_out) begin
                        n_phase     = PH_ERROR;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BAD;
                    end else begin
                        n_burst_address = {24'd0, byte_val & ADDR_LOW_MASK};
                        n_phase         = PH_ADDR_H;
                    end
                end
                PH_ADDR_H: begin
                    if (pos_out) begin
                        n_phase     = PH_ERROR;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BAD;
                    end else begin
                        n_burst_address = {16'd0, byte_val, r_burst_address[7:0]}
                                          + i_cfg.reg_base;
                        n_byte_in_word  = '0;
                        n_word_acc      = '0;
                        n_phase         = PH_DATA;
                    end
                end
                PH_DATA: begin
                    case (r_byte_in_word)
                        2'd0: begin
                            if (word_out) begin
                                n_phase     = PH_ERROR;
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_BAD;
                            end else begin
                                n_word_acc     = {16'd0, byte_val};
                                n_byte_in_word = 2'd1;
                            end
                        end
                        2'd1: begin
                            n_word_acc[15:8] = byte_val;
                            n_byte_in_word   = 2'd2;
                        end
                        2'd2: begin
                            n_word_acc[23:16] = byte_val;
                            n_byte_in_word    = 2'd3;
                        end
                        default: begin
                            // Last byte of a word: emit the register write
                            o_res_valid         = 1'b1;
                            o_res.kind          = KIND_WRITE;
                            o_res.write_address = r_burst_address;
                            o_res.write_data    = {byte_val, r_word_acc};
                            n_burst_address     = r_burst_address + WORD_STEP;
                            n_byte_in_word      = '0;
                            n_word_acc          = '0;
                            n_words_left        = r_words_left - 8'd1;
                            if (r_words_left == 8'd1) begin
                                n_phase = PH_LEN;
                            end
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end

        // Only a transaction that moves on produces a result
        if (!(i_item_valid && i_go)) begin
            o_res_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_phase         <= PH_LEN;
            r_words_left    <= '0;
            r_burst_address <= '0;
            r_word_acc      <= '0;
            r_byte_in_word  <= '0;
        end else if (i_item_valid && i_go) begin
            r_byte_position <= n_byte_position;
            r_phase         <= n_phase;
            r_words_left    <= n_words_left;
            r_burst_address <= n_burst_address;
            r_word_acc      <= n_word_acc;
            r_byte_in_word  <= n_byte_in_word;
        end
    end

    // A partial word exists only while data bytes are being collected
    a_word_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_in_word != 2'd0) |-> (r_phase == PH_DATA))
        else $error("partial word outside the data phase");

    // A burst in progress always has words left to deliver
    a_words_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ADDR_L || r_phase == PH_ADDR_H || r_phase == PH_DATA)
        |-> (r_words_left != 8'd0))
        else $error("burst in progress with no words left");

    // Bytes after the end of the list do not move the position
    a_hold_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && i_go && i_item.op == OP_BYTE
         && (r_phase == PH_DONE || r_phase == PH_ERROR))
        |=> $stable(r_byte_position))
        else $error("position moved after the list ended");

    // A finished report always points inside the region
    a_done_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_DONE)
        |-> (o_res.table_offset < i_cfg.region_length && o_res.table_offset[1:0] == 2'd0))
        else $error("finished report outside the region");

endmodule

// ===== rtl/brl_out_stage.sv =====
// ============================================================================
// Result register stage
// Holds one result transaction until the downstream side takes it.
// ============================================================================
module brl_out_stage
    import brl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Valid flag: a load always finds the register free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/burst_record_register_loader.sv =====
// An accepted input transaction is held in the input register; its result is then
// registered in the result register, from which it is taken.
// Throughput: one image byte per cycle while the result side does not stall; the parse
// state is updated as each byte moves from the input register to the result register.
// With the input register full, result back-pressure stalls the input in the same cycle.
// Reset (synchronous, active low) clears the parse state and restores the
// configuration registers to their defaults (region length 1024).
// ============================================================================
// Burst record register loader
// Parses the burst record list of a calibration image into register writes.
// ============================================================================
module burst_record_register_loader
    import brl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] image_byte
    input  logic         s_axis_tuser,   // [0] op
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] write_address, [63:32] write_data,
                                         // [79:64] table_offset, [95:80] table_length
    output logic [1:0]   m_axis_tuser    // [1:0] kind
);

    t_cfg     r_cfg;
    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     go;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reg_base      <= '0;
            r_cfg.region_length <= REGION_RESET;
            r_cfg.mac_address   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REG_BASE:      r_cfg.reg_base      <= i_cfg_data[31:0];
                CFG_REGION_LENGTH: r_cfg.region_length <= i_cfg_data[15:0];
                CFG_MAC_ADDRESS:   r_cfg.mac_address   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.op         = s_axis_tuser;
    assign in_item.image_byte = s_axis_tdata;

    // The held byte moves on when the result register is free or draining
    assign go = stage_valid && (!m_axis_tvalid || m_axis_tready);

    brl_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (go),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    brl_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (stage_valid),
        .i_item       (stage_item),
        .i_go         (go),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    brl_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    // Result packing
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {out_res.table_length, out_res.table_offset,
                           out_res.write_data, out_res.write_address};

endmodule

// ===== tb/tb_burst_record_register_loader.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Burst record register loader testbench
// Streams calibration images through the loader under several configurations,
// predicts every register write, list-finished and malformed transaction in a
// scoreboard, and compares each result field by field with random back-pressure.
// ============================================================================
import brl_pkg::*;

class burst_loader_scoreboard;

    // Configuration as the block sees it
    logic [31:0] reg_base;
    logic [15:0] region_length;
    logic [47:0] station_mac;

    // Parse state
    logic [15:0] position;
    logic [2:0]  phase;
    logic [7:0]  words_left;
    logic [31:0] burst_addr;
    logic [23:0] word_acc;
    logic [1:0]  byte_idx;

    t_result     awaited_results[$];
    int          mismatch_count;

    function new();
        reg_base       = '0;
        region_length  = REGION_RESET;
        station_mac    = '0;
        mismatch_count = 0;
        restart_parse();
    endfunction

    function void write_register(input logic [1:0] index, input logic [47:0] value);
        case (index)
            CFG_REG_BASE:      reg_base      = value[31:0];
            CFG_REGION_LENGTH: region_length = value[15:0];
            CFG_MAC_ADDRESS:   station_mac   = value;
            default: ;
        endcase
    endfunction

    function void restart_parse();
        position   = '0;
        phase      = PH_LEN;
        words_left = '0;
        burst_addr = '0;
        word_acc   = '0;
        byte_idx   = '0;
    endfunction

    // Station address bytes replace the image bytes at fixed offsets.
    function logic [7:0] patch(input logic [15:0] at, input logic [7:0] raw);
        case (at)
            MAC_OFS_0: return station_mac[7:0];
            MAC_OFS_1: return station_mac[15:8];
            MAC_OFS_2: return station_mac[23:16];
            MAC_OFS_3: return station_mac[31:24];
            MAC_OFS_4: return station_mac[39:32];
            MAC_OFS_5: return station_mac[47:40];
            default:   return raw;
        endcase
    endfunction

    function void push_result(input logic [1:0] kind, input logic [31:0] addr,
                              input logic [31:0] data, input logic [15:0] offset,
                              input logic [15:0] length);
        t_result r;
        r.kind          = kind;
        r.write_address = addr;
        r.write_data    = data;
        r.table_offset  = offset;
        r.table_length  = length;
        awaited_results.push_back(r);
    endfunction

    function void flag_malformed();
        phase = PH_ERROR;
        push_result(KIND_BAD, '0, '0, '0, '0);
    endfunction

    // Advance the parse by one accepted input transaction.
    function void note_image_transaction(input logic op, input logic [7:0] raw);
        logic [15:0] cur;
        logic [7:0]  b;
        logic [16:0] table_start;
        if (op == OP_RESTART) begin
            restart_parse();
            return;
        end
        if (phase == PH_DONE || phase == PH_ERROR)
            return;
        cur      = position;
        b        = patch(cur, raw);
        position = cur + 16'd1;
        case (phase)
            PH_LEN: begin
                if (cur >= region_length) begin
                    flag_malformed();
                end else if (b == 8'h00) begin
                    // Tables begin seven bytes past the terminator, rounded up to 4.
                    table_start = ({1'b0, cur} + 17'd10) & 17'h1FFFC;
                    if (table_start >= {1'b0, region_length}) begin
                        flag_malformed();
                    end else begin
                        phase = PH_DONE;
                        push_result(KIND_DONE, '0, '0, table_start[15:0],
                                    region_length - table_start[15:0]);
                    end
                end else begin
                    words_left = b;
                    phase      = PH_ADDR_L;
                end
            end
            PH_ADDR_L: begin
                if (cur >= region_length) begin
                    flag_malformed();
                end else begin
                    burst_addr = {24'd0, b & 8'hFE};
                    phase      = PH_ADDR_H;
                end
            end
            PH_ADDR_H: begin
                if (cur >= region_length) begin
                    flag_malformed();
                end else begin
                    burst_addr = {16'd0, b, burst_addr[7:0]} + reg_base;
                    byte_idx   = '0;
                    word_acc   = '0;
                    phase      = PH_DATA;
                end
            end
            default: begin
                case (byte_idx)
                    2'd0: begin
                        // The whole word must fit in the region.
                        if ({1'b0, cur} + 17'd3 >= {1'b0, region_length}) begin
                            flag_malformed();
                        end else begin
                            word_acc = {16'd0, b};
                            byte_idx = 2'd1;
                        end
                    end
                    2'd1: begin
                        word_acc[15:8] = b;
                        byte_idx       = 2'd2;
                    end
                    2'd2: begin
                        word_acc[23:16] = b;
                        byte_idx        = 2'd3;
                    end
                    default: begin
                        push_result(KIND_WRITE, burst_addr, {b, word_acc}, '0, '0);
                        burst_addr = burst_addr + 32'd4;
                        byte_idx   = '0;
                        word_acc   = '0;
                        words_left = words_left - 8'd1;
                        if (words_left == 8'd0)
                            phase = PH_LEN;
                    end
                endcase
            end
        endcase
    endfunction

    // Compare one accepted result transaction with the oldest prediction.
    function void check_result(input logic [1:0] kind, input logic [95:0] data);
        t_result expd;
        bit      wrong;
        if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected result: kind %0d tdata %h", kind, data);
            return;
        end
        expd  = awaited_results.pop_front();
        wrong = (kind != expd.kind)
             || (data[31:0]  != expd.write_address)
             || (data[63:32] != expd.write_data)
             || (data[79:64] != expd.table_offset)
             || (data[95:80] != expd.table_length);
        if (wrong) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Mismatch: expected kind %0d addr %h data %h offset %h length %h",
                         expd.kind, expd.write_address, expd.write_data,
                         expd.table_offset, expd.table_length);
                $display("          actual   kind %0d addr %h data %h offset %h length %h",
                         kind, data[31:0], data[63:32], data[79:64], data[95:80]);
            end
        end
    endfunction

endclass

module tb_burst_record_register_loader;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_REG_BASE;
    logic [47:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] image_byte
    logic        s_axis_tuser  = OP_BYTE; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [95:0] m_axis_tdata;          // [31:0] write_address, [63:32] write_data,
                                        // [79:64] table_offset, [95:80] table_length
    logic [1:0]  m_axis_tuser;          // [1:0] kind

    burst_loader_scoreboard scoreboard = new();
    logic [7:0] image_bytes[$];
    bit         idling_enabled = 1'b1;
    int         items_sent     = 0;
    int         stall_left     = 0;
    int         quiet_cycles   = 0;

    burst_record_register_loader dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random receiver back-pressure while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idling_enabled && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor both streams at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            scoreboard.check_result(m_axis_tuser, m_axis_tdata);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            scoreboard.note_image_transaction(s_axis_tuser, s_axis_tdata);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one input transaction, with an optional random gap before it.
    task automatic send_item(input logic op, input logic [7:0] data);
        if (idling_enabled && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_image(input int count);
        for (int k = 0; k < count; k++)
            send_item(OP_BYTE, image_bytes[k]);
    endtask

    // Stop sending until every predicted result has been received.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (scoreboard.awaited_results.size() != 0);
    endtask

    // Drain, then give the pipeline time to finish bytes that produce no result.
    task automatic settle_idle();
        hold_until_drained();
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] base, input logic [15:0] region,
                               input logic [47:0] mac);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_REG_BASE;
        i_cfg_data  <= {16'd0, base};
        @(negedge i_clk);
        i_cfg_index <= CFG_REGION_LENGTH;
        i_cfg_data  <= {32'd0, region};
        @(negedge i_clk);
        i_cfg_index <= CFG_MAC_ADDRESS;
        i_cfg_data  <= mac;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.write_register(CFG_REG_BASE, {16'd0, base});
        scoreboard.write_register(CFG_REGION_LENGTH, {32'd0, region});
        scoreboard.write_register(CFG_MAC_ADDRESS, mac);
    endtask

    // Mostly short bursts, occasionally long ones up to the full 255 words.
    function automatic logic [7:0] pick_burst_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 8'($urandom_range(1, 4));
        if (r < 97)
            return 8'($urandom_range(5, 16));
        return ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(17, 254));
    endfunction

    // Build a burst record list that stays well formed after address patching.
    function automatic void build_image(input int n_records);
        int         p;
        logic [7:0] raw;
        logic [7:0] eff;
        image_bytes.delete();
        p = 0;
        for (int r = 0; r <= n_records; r++) begin
            raw = (r == n_records) ? 8'h00 : pick_burst_length();
            eff = scoreboard.patch(16'(p), raw);
            image_bytes.push_back(raw);
            p++;
            if (eff == 8'h00)
                break;
            repeat (2 + 4 * int'(eff)) begin
                image_bytes.push_back(8'($urandom));
                p++;
            end
        end
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] pick_mac();
        case ($urandom_range(0, 3))
            0:       return 48'h0;
            1:       return 48'hFFFF_FFFF_FFFF;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [15:0] pick_region(input int ph);
        case (ph)
            0:       return 16'd65535;
            1:       return 16'd1;
            2, 7:    return REGION_RESET;
            3:       return 16'($urandom_range(8, 48));
            4:       return 16'($urandom_range(49, 65535));
            5:       return 16'($urandom_range(12, 40));
            default: return 16'($urandom_range(100, 4000));
        endcase
    endfunction

    // Main stimulus.
    initial begin
        int phase_end;
        int choice;
        int images;
        int cut;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // One burst wrapping the address space, then an empty list.
        load_config(32'hFFFF_FFF0, REGION_RESET, 48'h0123_4567_89AB);
        send_item(OP_RESTART, 8'h5A);
        image_bytes = '{8'h01, 8'h01, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00};
        send_image(image_bytes.size());
        send_item(OP_RESTART, 8'hFF);
        send_item(OP_BYTE, 8'h00);

        // Length byte beyond the region after a complete burst.
        settle_idle();
        load_config(32'h0000_0000, 16'd7, 48'hFFFF_FFFF_FFFF);
        send_item(OP_RESTART, 8'h00);
        image_bytes = '{8'h01, 8'h00, 8'h80, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h05};
        send_image(image_bytes.size());

        // Word that does not fit in the region.
        settle_idle();
        load_config(32'hFFFF_FFFF, 16'd5, 48'h0);
        send_item(OP_RESTART, 8'h81);
        image_bytes = '{8'h02, 8'h10, 8'h20, 8'h33};
        send_image(image_bytes.size());

        // Table start beyond the region, then an address byte beyond it.
        settle_idle();
        load_config(32'h8000_0000, 16'd2, 48'h8000_0000_0001);
        send_item(OP_RESTART, 8'h7E);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h7F);
        send_item(OP_RESTART, 8'h01);
        image_bytes = '{8'h01, 8'h00, 8'h00};
        send_image(image_bytes.size());

        // Random images under a series of configurations.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_idle();
            load_config(pick_base(), pick_region(ph), pick_mac());
            idling_enabled = (ph != 2) && (ph != RANDOM_PHASES - 1);
            phase_end = items_sent + ((ph == 1) ? 60 : 210);
            images = 0;
            while (items_sent < phase_end) begin
                choice = $urandom_range(0, 19);
                send_item(OP_RESTART, 8'($urandom));
                if (choice < 18) begin
                    build_image($urandom_range(0, 5));
                    cut = (choice < 15) ? image_bytes.size()
                                        : $urandom_range(1, image_bytes.size());
                    // Long images are cut off at the end of the phase's byte budget.
                    if (cut > phase_end - items_sent)
                        cut = phase_end - items_sent;
                    send_image(cut);
                    // Bytes after the end of the list are ignored.
                    if (choice < 15)
                        repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 24))
                        send_item(($urandom_range(0, 7) == 0) ? OP_RESTART : OP_BYTE,
                                  8'($urandom));
                end
                images++;
                if (ph == 0 && images == 3)
                    hold_until_drained();
            end
        end

        settle_idle();
        if (scoreboard.mismatch_count == 0 && scoreboard.awaited_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
